// File: rtl/date_day_difference_top_assert.svh
// Assertion helpers used by the top-level RTL.
`ifndef DATE_DAY_DIFFERENCE_TOP_ASSERT_SVH
`define DATE_DAY_DIFFERENCE_TOP_ASSERT_SVH

// checked only outside reset
`define DDD_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked at every edge, reset included
`define DDD_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: rtl/ddd_pkg.sv
package ddd_pkg;

   typedef logic signed [8:0]  char_val_type;   // byte minus 48
   typedef logic signed [12:0] two_digit_type;  // day or month
   typedef logic signed [18:0] year_type;
   typedef logic signed [27:0] day_num_type;

   typedef enum logic [1:0] {
      STATUS_OK              = 2'd0,
      STATUS_END_BEFORE_START = 2'd1,
      STATUS_BAD_MONTH       = 2'd2
   } status_type;

   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
   } stage_en_type;

   localparam year_type BASE_YEAR = 19'sd2000;
   localparam day_num_type LEAPS_BEFORE_BASE = 28'sd484;  // leap years in 1..1999
   localparam logic [21:0] DIFF_MAX = 22'd4194303;

   // floor(q/25) = (q * RECIP) >> SHIFT, exact over the operand ranges used
   localparam logic [16:0] RECIP25_Q4 = 17'd83887;    // q < 2^16
   localparam int          SHIFT_Q4   = 21;
   localparam logic [18:0] RECIP25_YR = 19'd335545;   // a < 2^18
   localparam int          SHIFT_YR   = 23;

   function automatic char_val_type char_val(input logic [63:0] w, input int pos);
      logic [7:0] b;
      b = w[63 - 8*pos -: 8];
      return char_val_type'({1'b0, b}) - 9'sd48;
   endfunction

   function automatic logic [8:0] days_before_month(input logic [3:0] idx);
      logic [8:0] r;
      unique case (idx)
         4'd0:    r = 9'd0;
         4'd1:    r = 9'd31;
         4'd2:    r = 9'd59;
         4'd3:    r = 9'd90;
         4'd4:    r = 9'd120;
         4'd5:    r = 9'd151;
         4'd6:    r = 9'd181;
         4'd7:    r = 9'd212;
         4'd8:    r = 9'd243;
         4'd9:    r = 9'd273;
         4'd10:   r = 9'd304;
         4'd11:   r = 9'd334;
         default: r = 9'd0;
      endcase
      return r;
   endfunction

endpackage

// File: rtl/ddd_lane.sv
module ddd_lane (
   input  logic                 clock,
   input  ddd_pkg::stage_en_type en,
   input  logic [63:0]          date_chars,
   output ddd_pkg::day_num_type day_num,
   output logic                 month_ok
);

   // stage 1: digits to day, month, year
   ddd_pkg::two_digit_type d_s1_ff, m_s1_ff;
   ddd_pkg::year_type      y_s1_ff;
   ddd_pkg::two_digit_type d_s1_in, m_s1_in;
   ddd_pkg::year_type      y_s1_in;

   always_comb begin
      d_s1_in = 13'(ddd_pkg::char_val(date_chars, 0)) * 13'sd10
              + 13'(ddd_pkg::char_val(date_chars, 1));
      m_s1_in = 13'(ddd_pkg::char_val(date_chars, 2)) * 13'sd10
              + 13'(ddd_pkg::char_val(date_chars, 3));
      y_s1_in = 19'(ddd_pkg::char_val(date_chars, 4)) * 19'sd1000
              + 19'(ddd_pkg::char_val(date_chars, 5)) * 19'sd100
              + 19'(ddd_pkg::char_val(date_chars, 6)) * 19'sd10
              + 19'(ddd_pkg::char_val(date_chars, 7));
   end

   always_ff @(posedge clock) begin
      if (en.s1) begin
         d_s1_ff <= d_s1_in;
         m_s1_ff <= m_s1_in;
         y_s1_ff <= y_s1_in;
      end
   end

   // stage 2: month table, year days, reciprocal products
   ddd_pkg::two_digit_type d_s2_ff;
   logic                   mok_s2_ff, mok_s2_in;
   logic [8:0]             dbm_s2_ff, dbm_s2_in;
   logic                   late_s2_ff, late_s2_in;
   logic                   after_s2_ff, after_s2_in;
   logic [26:0]            y365_s2_ff, y365_s2_in;
   logic [15:0]            q4_s2_ff, q4_s2_in;
   logic [32:0]            p100_s2_ff, p100_s2_in;
   logic [17:0]            mag_s2_ff, mag_s2_in;
   logic [36:0]            p25_s2_ff, p25_s2_in;
   ddd_pkg::year_type      yoff, yprev;
   ddd_pkg::two_digit_type m_idx;

   always_comb begin
      mok_s2_in   = (m_s1_ff >= 13'sd1) && (m_s1_ff <= 13'sd12);
      m_idx       = m_s1_ff - 13'sd1;
      dbm_s2_in   = mok_s2_in ? ddd_pkg::days_before_month(m_idx[3:0]) : 9'd0;
      late_s2_in  = m_s1_ff > 13'sd2;
      after_s2_in = y_s1_ff > ddd_pkg::BASE_YEAR;
      yoff        = y_s1_ff - ddd_pkg::BASE_YEAR;
      yprev       = y_s1_ff - 19'sd1;
      y365_s2_in  = 27'(yoff[17:0]) * 27'd365;
      q4_s2_in    = yprev[17:2];
      p100_s2_in  = 33'(q4_s2_in) * 33'(ddd_pkg::RECIP25_Q4);
      mag_s2_in   = y_s1_ff[18] ? 18'(-y_s1_ff) : y_s1_ff[17:0];
      p25_s2_in   = 37'(mag_s2_in) * 37'(ddd_pkg::RECIP25_YR);
   end

   always_ff @(posedge clock) begin
      if (en.s2) begin
         d_s2_ff     <= d_s1_ff;
         mok_s2_ff   <= mok_s2_in;
         dbm_s2_ff   <= dbm_s2_in;
         late_s2_ff  <= late_s2_in;
         after_s2_ff <= after_s2_in;
         y365_s2_ff  <= y365_s2_in;
         q4_s2_ff    <= q4_s2_in;
         p100_s2_ff  <= p100_s2_in;
         mag_s2_ff   <= mag_s2_in;
         p25_s2_ff   <= p25_s2_in;
      end
   end

   // stage 3: leap count, leap test, sum
   ddd_pkg::day_num_type day_s3_ff, day_s3_in;
   logic                 mok_s3_ff;
   logic [11:0]          q100;
   logic [13:0]          mag25;
   logic [17:0]          mag25x;
   logic                 div25, leap;
   ddd_pkg::day_num_type leaps, year_part, month_part;

   always_comb begin
      q100   = p100_s2_ff[ddd_pkg::SHIFT_Q4 +: 12];
      leaps  = 28'(q4_s2_ff) - 28'(q100) + 28'(q100[11:2]) - ddd_pkg::LEAPS_BEFORE_BASE;
      mag25  = p25_s2_ff[ddd_pkg::SHIFT_YR +: 14];
      mag25x = 18'(mag25) * 18'd25;
      div25  = mag25x == mag_s2_ff;
      leap   = ((mag_s2_ff[1:0] == 2'd0) && !div25) || ((mag_s2_ff[3:0] == 4'd0) && div25);
      year_part  = after_s2_ff ? 28'(y365_s2_ff) + leaps : 28'sd0;
      month_part = mok_s2_ff ? 28'(dbm_s2_ff) + 28'(late_s2_ff && leap) : 28'sd0;
      day_s3_in  = year_part + month_part + 28'(d_s2_ff);
   end

   always_ff @(posedge clock) begin
      if (en.s3) begin
         day_s3_ff <= day_s3_in;
         mok_s3_ff <= mok_s2_ff;
      end
   end

   assign day_num  = day_s3_ff;
   assign month_ok = mok_s3_ff;

endmodule

// File: rtl/ddd_merge.sv
module ddd_merge (
   input  logic                 clock,
   input  logic                 load,
   input  ddd_pkg::day_num_type start_day,
   input  ddd_pkg::day_num_type end_day,
   input  logic                 start_ok,
   input  logic                 end_ok,
   output logic [21:0]          day_difference,
   output logic [1:0]           status
);

   logic signed [28:0] diff;
   logic [21:0]        diff_ff, diff_in;
   logic [1:0]         status_ff, status_in;

   always_comb begin
      diff = 29'(end_day) - 29'(start_day);
      priority if (!start_ok || !end_ok) begin
         status_in = ddd_pkg::STATUS_BAD_MONTH;
         diff_in   = 22'd0;
      end else if (diff < 29'sd0) begin
         status_in = ddd_pkg::STATUS_END_BEFORE_START;
         diff_in   = 22'd0;
      end else if (diff > 29'(ddd_pkg::DIFF_MAX)) begin
         status_in = ddd_pkg::STATUS_OK;
         diff_in   = ddd_pkg::DIFF_MAX;
      end else begin
         status_in = ddd_pkg::STATUS_OK;
         diff_in   = diff[21:0];
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         diff_ff   <= diff_in;
         status_ff <= status_in;
      end
   end

   assign day_difference = diff_ff;
   assign status         = status_ff;

endmodule

// File: rtl/date_day_difference_top.sv
// channel | direction | handshake             | payload
// req     | in        | req_valid / req_ready | req_start_date_chars, req_end_date_chars
// rsp     | out       | rsp_valid / rsp_ready | rsp_day_difference, rsp_status
//
// One item per cycle sustained while rsp_ready stays high; three lane stages, one merge stage.
// Two identical lanes convert the start and end dates; the merge stage subtracts.
// Each stage advances when the stage after it is empty or moving, so bubbles collapse.
// A stalled rsp side holds the pipeline; up to four items are in flight.
// Synchronous reset clears the stage valid bits only.
`include "date_day_difference_top_assert.svh"

module date_day_difference_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_start_date_chars,
   input  logic [63:0] req_end_date_chars,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [21:0] rsp_day_difference,
   output logic [1:0]  rsp_status
);

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic v1_in, v2_in, v3_in, v4_in;
   logic rdy1, rdy2, rdy3, rdy4;
   ddd_pkg::stage_en_type en;

   always_comb begin
      rdy4  = !v4_ff || rsp_ready;
      rdy3  = !v3_ff || rdy4;
      rdy2  = !v2_ff || rdy3;
      rdy1  = !v1_ff || rdy2;
      v1_in = rdy1 ? req_valid : v1_ff;
      v2_in = rdy2 ? v1_ff : v2_ff;
      v3_in = rdy3 ? v2_ff : v3_ff;
      v4_in = rdy4 ? v3_ff : v4_ff;
      en.s1 = rdy1;
      en.s2 = rdy2;
      en.s3 = rdy3;
      en.s4 = rdy4;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   ddd_pkg::day_num_type start_day, end_day;
   logic                 start_ok, end_ok;

   ddd_lane u_lane_start (
      .clock      (clock),
      .en         (en),
      .date_chars (req_start_date_chars),
      .day_num    (start_day),
      .month_ok   (start_ok)
   );

   ddd_lane u_lane_end (
      .clock      (clock),
      .en         (en),
      .date_chars (req_end_date_chars),
      .day_num    (end_day),
      .month_ok   (end_ok)
   );

   ddd_merge u_merge (
      .clock          (clock),
      .load           (en.s4),
      .start_day      (start_day),
      .end_day        (end_day),
      .start_ok       (start_ok),
      .end_ok         (end_ok),
      .day_difference (rsp_day_difference),
      .status         (rsp_status)
   );

   assign req_ready = rdy1;
   assign rsp_valid = v4_ff;

   `DDD_ASSERT_ALWAYS(a_reset_empties, reset |=> !rsp_valid && !v1_ff, "pipeline not empty after reset")
   `DDD_ASSERT(a_accept_enters, req_valid && req_ready |=> v1_ff, "accepted item missing from stage 1")
   `DDD_ASSERT(a_status_code, rsp_valid |-> (rsp_status == ddd_pkg::STATUS_OK || rsp_status == ddd_pkg::STATUS_END_BEFORE_START || rsp_status == ddd_pkg::STATUS_BAD_MONTH), "bad status code")
   `DDD_ASSERT(a_err_zero_diff, rsp_valid && rsp_status != ddd_pkg::STATUS_OK |-> rsp_day_difference == 22'd0, "nonzero difference with error status")
   `DDD_ASSERT(a_stage_moves, v3_ff && !rsp_valid |=> rsp_valid, "stage 3 item did not reach output")

endmodule

// File: dv/date_day_difference_top_tb.sv
module date_day_difference_top_tb;

   localparam int     RANDOM_ITEMS = 1500;
   localparam int     CYCLE_LIMIT  = 200000;
   localparam int     DRAIN_CYCLES = 8;
   localparam int     HOLD_CYCLES  = 80;
   localparam longint EPOCH_YEAR   = 2000;
   localparam longint DAYS_CAP     = 4194303;
   localparam int     MONTH_START [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

   typedef struct {
      logic [21:0]         days;
      ddd_pkg::status_type status;
   } span_type;

   typedef struct {
      logic [63:0] start_w;
      logic [63:0] end_w;
      bit          golden;
      span_type    want;
   } plan_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic [63:0] req_start_date_chars = '0;
   logic [63:0] req_end_date_chars = '0;
   logic        rsp_ready = 1'b0;
   logic        req_ready;
   logic        rsp_valid;
   logic [21:0] rsp_day_difference;
   logic [1:0]  rsp_status;

   span_type     span_queue [$];
   plan_row_type plan [$];
   int           cycle_count = 0;
   int           mismatches = 0;
   int           results_checked = 0;
   int           saturated_seen = 0;
   int           bad_month_seen = 0;
   int           reversed_seen = 0;
   bit           burst_mode = 1'b0;

   date_day_difference_top dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_start_date_chars (req_start_date_chars),
      .req_end_date_chars   (req_end_date_chars),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_day_difference   (rsp_day_difference),
      .rsp_status           (rsp_status)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timed out after %0d cycles, %0d items outstanding",
                  cycle_count, span_queue.size());
         $display("date_day_difference_top_tb: FAIL");
         $finish;
      end
   end

   // ---------------- day-count predictor ----------------

   // byte minus '0', so any byte maps to -48..207
   function automatic longint char_digit(logic [63:0] w, int pos);
      return longint'({56'd0, w[63 - 8*pos -: 8]}) - 48;
   endfunction

   function automatic longint month_field(logic [63:0] w);
      return char_digit(w, 2) * 10 + char_digit(w, 3);
   endfunction

   function automatic bit is_leap(longint y);
      longint a;
      a = (y < 0) ? -y : y;
      return ((a % 4 == 0) && (a % 100 != 0)) || (a % 400 == 0);
   endfunction

   function automatic longint leaps_through(longint n);
      return n / 4 - n / 100 + n / 400;
   endfunction

   function automatic longint day_index(logic [63:0] w);
      longint d, m, y, total;
      d = char_digit(w, 0) * 10 + char_digit(w, 1);
      m = month_field(w);
      y = char_digit(w, 4) * 1000 + char_digit(w, 5) * 100 +
          char_digit(w, 6) * 10 + char_digit(w, 7);
      total = 0;
      // years before the epoch add nothing
      if (y > EPOCH_YEAR)
         total = 365 * (y - EPOCH_YEAR) + leaps_through(y - 1) - leaps_through(EPOCH_YEAR - 1);
      if (m >= 1 && m <= 12) begin
         total += MONTH_START[m - 1];
         if (m > 2 && is_leap(y))
            total += 1;
      end
      return total + d;
   endfunction

   function automatic span_type predict_span(logic [63:0] s, logic [63:0] e);
      span_type r;
      longint   ms, me, gap;
      r.days   = '0;
      r.status = ddd_pkg::STATUS_OK;
      ms = month_field(s);
      me = month_field(e);
      if (ms < 1 || ms > 12 || me < 1 || me > 12) begin
         r.status = ddd_pkg::STATUS_BAD_MONTH;
      end else begin
         gap = day_index(e) - day_index(s);
         if (gap < 0)
            r.status = ddd_pkg::STATUS_END_BEFORE_START;
         else if (gap > DAYS_CAP)
            r.days = DAYS_CAP[21:0];
         else
            r.days = gap[21:0];
      end
      return r;
   endfunction

   // ---------------- stimulus helpers ----------------

   function automatic logic [63:0] date_word(int d, int m, int y);
      return {8'h30 + 8'(d / 10), 8'h30 + 8'(d % 10),
              8'h30 + 8'(m / 10), 8'h30 + 8'(m % 10),
              8'h30 + 8'(y / 1000), 8'h30 + 8'((y / 100) % 10),
              8'h30 + 8'((y / 10) % 10), 8'h30 + 8'(y % 10)};
   endfunction

   function automatic logic [63:0] random_date();
      int          kind;
      logic [63:0] w;
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
         w = date_word($urandom_range(1, 31), $urandom_range(1, 12),
                       $urandom_range(1995, 2405));
      end else if (kind < 70) begin
         w = date_word($urandom_range(0, 99), $urandom_range(1, 12), $urandom_range(0, 9999));
      end else if (kind < 78) begin
         w = date_word($urandom_range(0, 99),
                       ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(13, 99),
                       $urandom_range(0, 9999));
      end else if (kind < 88) begin
         w = {$urandom, $urandom};
      end else begin
         // well-formed date with one garbage character
         w = date_word($urandom_range(1, 31), $urandom_range(1, 12), $urandom_range(0, 9999));
         w[8 * $urandom_range(0, 7) +: 8] = 8'($urandom);
      end
      return w;
   endfunction

   function automatic void add_row(logic [63:0] s, logic [63:0] e, bit golden,
                                   logic [21:0] days, ddd_pkg::status_type st);
      plan_row_type r;
      r.start_w     = s;
      r.end_w       = e;
      r.golden      = golden;
      r.want.days   = days;
      r.want.status = st;
      plan.push_back(r);
   endfunction

   task automatic offer(input logic [63:0] s, input logic [63:0] e, input span_type want);
      int gap;
      gap = burst_mode ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid            <= 1'b1;
      req_start_date_chars <= s;
      req_end_date_chars   <= e;
      do @(posedge clock); while (!req_ready);
      span_queue.push_back(want);
   endtask

   // ---------------- sender ----------------

   initial begin : stimulus
      logic [63:0] s, e;
      span_type    want;

      add_row("01012000", "01012000", 1, 22'd0, ddd_pkg::STATUS_OK);
      add_row("01012000", "01012001", 1, 22'd366, ddd_pkg::STATUS_OK);
      add_row("01132000", "01012000", 1, 22'd0, ddd_pkg::STATUS_BAD_MONTH);
      add_row("01012000", "01002000", 1, 22'd0, ddd_pkg::STATUS_BAD_MONTH);
      add_row(64'h0, 64'h0, 1, 22'd0, ddd_pkg::STATUS_BAD_MONTH);
      add_row({8{8'hFF}}, {8{8'hFF}}, 1, 22'd0, ddd_pkg::STATUS_BAD_MONTH);
      add_row("02012000", "01012000", 1, 22'd0, ddd_pkg::STATUS_END_BEFORE_START);
      add_row("01012000", {"0101", 32'hFFFF_FFFF}, 1, 22'd4194303, ddd_pkg::STATUS_OK);
      add_row("01122000", "31122000", 0, '0, ddd_pkg::STATUS_OK);
      add_row("28022000", "01032000", 0, '0, ddd_pkg::STATUS_OK);
      add_row("28021900", "01031900", 0, '0, ddd_pkg::STATUS_OK);
      add_row("28022100", "01032100", 0, '0, ddd_pkg::STATUS_OK);
      add_row("28022400", "01032400", 0, '0, ddd_pkg::STATUS_OK);
      add_row("01011999", "01012000", 0, '0, ddd_pkg::STATUS_OK);
      add_row("00012000", "99122000", 0, '0, ddd_pkg::STATUS_OK);
      add_row("31121999", "01012400", 0, '0, ddd_pkg::STATUS_OK);
      add_row("0103/996", "01012000", 0, '0, ddd_pkg::STATUS_OK);   // year -4, leap by magnitude
      add_row("0103/400", "01012000", 0, '0, ddd_pkg::STATUS_OK);
      add_row("AA012000", "01022000", 0, '0, ddd_pkg::STATUS_OK);   // non-digit day
      add_row("010:2000", "01112000", 0, '0, ddd_pkg::STATUS_OK);   // ':' makes month 10
      add_row("01010000", "01019999", 0, '0, ddd_pkg::STATUS_OK);
      add_row("01012000", "31129999", 0, '0, ddd_pkg::STATUS_OK);
      add_row({"0101", 32'h0000_0000}, "01012001", 0, '0, ddd_pkg::STATUS_OK);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         want = plan[i].golden ? plan[i].want : predict_span(plan[i].start_w, plan[i].end_w);
         offer(plan[i].start_w, plan[i].end_w, want);
      end

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // alternate stretches of random idling with back-to-back bursts
         if (n % 150 == 0)
            burst_mode = ((n / 150) % 3 == 1);
         s = random_date();
         e = ($urandom_range(0, 9) == 0) ? s : random_date();
         offer(s, e, predict_span(s, e));
      end
      req_valid <= 1'b0;

      while (span_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d date pairs sent (%0d directed), %0d results checked",
               plan.size() + RANDOM_ITEMS, plan.size(), results_checked);
      $display("bad month %0d, end before start %0d, saturated %0d, mismatches %0d",
               bad_month_seen, reversed_seen, saturated_seen, mismatches);
      if (mismatches == 0)
         $display("date_day_difference_top_tb: PASS");
      else
         $display("date_day_difference_top_tb: FAIL");
      $finish;
   end

   // ---------------- receiver and checker ----------------

   initial begin : result_side
      span_type want;
      int       stall;

      do @(posedge clock); while (reset);
      forever begin
         stall = burst_mode ? 0 : $urandom_range(0, 10);
         // long hold-off so the pipeline fills and backs up into req_ready
         if (results_checked == 300 || results_checked == 1000)
            stall = HOLD_CYCLES;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));

         if (span_queue.size() == 0) begin
            $error("result with no item outstanding: day_difference %0d status %0d",
                   rsp_day_difference, rsp_status);
            mismatches++;
         end else begin
            want = span_queue.pop_front();
            if (rsp_day_difference !== want.days) begin
               $error("day_difference: expected %0d, got %0d", want.days, rsp_day_difference);
               mismatches++;
            end
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               mismatches++;
            end
            if (want.status == ddd_pkg::STATUS_BAD_MONTH)
               bad_month_seen++;
            else if (want.status == ddd_pkg::STATUS_END_BEFORE_START)
               reversed_seen++;
            else if (want.days == DAYS_CAP[21:0])
               saturated_seen++;
         end
         results_checked++;
      end
   end

endmodule

// File: date_day_difference_top.f
+incdir+rtl
rtl/ddd_pkg.sv
rtl/ddd_lane.sv
rtl/ddd_merge.sv
rtl/date_day_difference_top.sv
dv/date_day_difference_top_tb.sv
